@@ rtl/core/vad_pkg.sv @@
`timescale 1ns / 1ps

package vad_pkg;

    localparam int COORD_W = 12;
    localparam int DATA_W  = 5;
    localparam int TAG_W   = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [COORD_W-1:0] BEAM_Y_HOME = 12'd3033;
    localparam logic [COORD_W-1:0] BEAM_X_HOME = 12'd0;

    // Keep masks for the short address forms.
    localparam logic [COORD_W-1:0] KEEP_LOW_EXTRA = 12'h07F;
    localparam logic [COORD_W-1:0] KEEP_HIGH_EXTRA = 12'hF83;
    localparam logic [COORD_W-1:0] KEEP_HIGH = 12'hF80;
    localparam logic [COORD_W-1:0] KEEP_EXTRA = 12'h003;

    // Tag values of the address forms.
    localparam logic [TAG_W-1:0] TAG_FULL12      = 10'h1F6;
    localparam logic [TAG_W-1:0] TAG_FULL10      = 10'h076;
    localparam logic [TAG_W-1:0] TAG_HY_LX       = 10'h006;
    localparam logic [TAG_W-1:0] TAG_LY_LX       = 10'h00E;
    localparam logic [TAG_W-1:0] TAG_LY_HX_LX    = 10'h036;
    localparam logic [TAG_W-1:0] TAG_LX          = 10'h002;
    localparam logic [TAG_W-1:0] TAG_E_LY_LX     = 10'h03E;
    localparam logic [TAG_W-1:0] TAG_HY_LY_LX    = 10'h01E;
    localparam logic [TAG_W-1:0] TAG_E_LY_HX_LX  = 10'h0F6;
    localparam logic [TAG_W-1:0] TAG_HY_E_LY_LX  = 10'h07E;
    localparam logic [TAG_W-1:0] TAG_HY_HX_LX    = 10'h016;

    localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEN_DOWN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_STYLE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTENSITY    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFOCUS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_THRU   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLOW_NORMAL  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLOW_THRU    = 3'd7;

    localparam logic [2:0] STYLE_MAX = 3'd4;

    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd2;

    typedef enum logic [3:0] {
        FORM_STEP,
        FORM_FULL12,
        FORM_FULL10,
        FORM_HY_LX,
        FORM_LY_LX,
        FORM_LY_HX_LX,
        FORM_LX,
        FORM_E_LY_LX,
        FORM_HY_LY_LX,
        FORM_E_LY_HX_LX,
        FORM_HY_E_LY_LX,
        FORM_HY_HX_LX
    } form_t;

    typedef struct packed {
        form_t             form;
        logic [DATA_W-1:0] d4;
        logic [DATA_W-1:0] d3;
        logic [DATA_W-1:0] d2;
        logic [DATA_W-1:0] d1;
        logic [DATA_W-1:0] d0;
        logic [3:0]        dirs;
    } cmd_t;

    typedef struct packed {
        logic [1:0] draw_mode;
        logic       pen_down;
        logic [2:0] line_style;
        logic [6:0] point_intensity;
        logic       beam_defocus;
        logic       beam_write_through;
        logic [7:0] glow_normal;
        logic [7:0] glow_through;
    } cfg_t;

endpackage

@@ rtl/core/vector_address_decoder_unit.sv @@
`timescale 1ns / 1ps
// An item that makes a record is first written into the command queue, and then popped
// into the back end's output register, which drives m_axis_tvalid and the record.
// Throughput: one item per cycle while m_axis_tready is high; the beam register update in the back end sets it.
// Input and output stall independently through a QUEUE_DEPTH-entry command queue.
// Reset (aresetn low, synchronous) homes the beam to y 3033, x 0, empties the queue
// and output register, and returns every configuration register to its default.
module vector_address_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_count, addr_byte0..addr_byte4, step_dirs, zero pad
    input  logic [47:0] s_axis_tdata,
    // operation
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pos_y, pos_x, glow, defocus_out, through_out, style_out, intensity_out, zero pad
    output logic [47:0] m_axis_tdata,
    // record_kind
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    vad_pkg::cfg_t cfg_reg;
    vad_pkg::cmd_t front_cmd;
    vad_pkg::cmd_t head_cmd;
    logic          push;
    logic          pop;
    logic          q_not_empty;
    logic          q_not_full;
    logic [1:0]    record_kind;
    logic [11:0]   pos_y;
    logic [11:0]   pos_x;
    logic [7:0]    glow;
    logic          defocus_out;
    logic          through_out;
    logic [2:0]    style_out;
    logic [6:0]    intensity_out;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = q_not_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.draw_mode          <= 2'd0;
            cfg_reg.pen_down           <= 1'b0;
            cfg_reg.line_style         <= 3'd0;
            cfg_reg.point_intensity    <= 7'd127;
            cfg_reg.beam_defocus       <= 1'b0;
            cfg_reg.beam_write_through <= 1'b0;
            cfg_reg.glow_normal        <= 8'd1;
            cfg_reg.glow_through       <= 8'd5;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vad_pkg::CFG_DRAW_MODE:    cfg_reg.draw_mode          <= cfg_data[1:0];
                vad_pkg::CFG_PEN_DOWN:     cfg_reg.pen_down           <= cfg_data[0];
                vad_pkg::CFG_LINE_STYLE:   cfg_reg.line_style         <= cfg_data[2:0];
                vad_pkg::CFG_INTENSITY:    cfg_reg.point_intensity    <= cfg_data[6:0];
                vad_pkg::CFG_DEFOCUS:      cfg_reg.beam_defocus       <= cfg_data[0];
                vad_pkg::CFG_WRITE_THRU:   cfg_reg.beam_write_through <= cfg_data[0];
                vad_pkg::CFG_GLOW_NORMAL:  cfg_reg.glow_normal        <= cfg_data;
                vad_pkg::CFG_GLOW_THRU:    cfg_reg.glow_through       <= cfg_data;
                default: ;
            endcase
        end
    end

    vad_front u_front (
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .operation  (s_axis_tuser[0]),
        .byte_count (s_axis_tdata[2:0]),
        .addr_byte0 (s_axis_tdata[9:3]),
        .addr_byte1 (s_axis_tdata[16:10]),
        .addr_byte2 (s_axis_tdata[23:17]),
        .addr_byte3 (s_axis_tdata[30:24]),
        .addr_byte4 (s_axis_tdata[37:31]),
        .step_dirs  (s_axis_tdata[41:38]),
        .push       (push),
        .cmd        (front_cmd)
    );

    vad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .not_empty (q_not_empty),
        .not_full  (q_not_full),
        .head_cmd  (head_cmd)
    );

    vad_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd_valid     (q_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .record_kind   (record_kind),
        .pos_y         (pos_y),
        .pos_x         (pos_x),
        .glow          (glow),
        .defocus_out   (defocus_out),
        .through_out   (through_out),
        .style_out     (style_out),
        .intensity_out (intensity_out)
    );

    assign m_axis_tuser = record_kind;
    assign m_axis_tdata = {4'b0, intensity_out, style_out, through_out, defocus_out,
                           glow, pos_x, pos_y};

endmodule

@@ rtl/core/vad_front.sv @@
`timescale 1ns / 1ps

module vad_front (
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              operation,
    input  logic [2:0]        byte_count,
    input  logic [6:0]        addr_byte0,
    input  logic [6:0]        addr_byte1,
    input  logic [6:0]        addr_byte2,
    input  logic [6:0]        addr_byte3,
    input  logic [6:0]        addr_byte4,
    input  logic [3:0]        step_dirs,
    output logic              push,
    output vad_pkg::cmd_t     cmd
);

    logic [vad_pkg::TAG_W-1:0] tag;
    logic                      count_ok;
    logic                      form_ok;
    vad_pkg::form_t            form;

    // The tag gathers bits 6:5 of the valid bytes, first byte in the highest pair.
    always_comb begin
        count_ok = 1'b1;
        tag      = '0;
        case (byte_count)
            3'd1: tag = {8'b0, addr_byte0[6:5]};
            3'd2: tag = {6'b0, addr_byte0[6:5], addr_byte1[6:5]};
            3'd3: tag = {4'b0, addr_byte0[6:5], addr_byte1[6:5], addr_byte2[6:5]};
            3'd4: tag = {2'b0, addr_byte0[6:5], addr_byte1[6:5], addr_byte2[6:5],
                         addr_byte3[6:5]};
            3'd5: tag = {addr_byte0[6:5], addr_byte1[6:5], addr_byte2[6:5],
                         addr_byte3[6:5], addr_byte4[6:5]};
            default: count_ok = 1'b0;
        endcase
    end

    always_comb begin
        form_ok = 1'b1;
        form    = vad_pkg::FORM_STEP;
        unique case (tag)
            vad_pkg::TAG_FULL12:     form = vad_pkg::FORM_FULL12;
            vad_pkg::TAG_FULL10:     form = vad_pkg::FORM_FULL10;
            vad_pkg::TAG_HY_LX:      form = vad_pkg::FORM_HY_LX;
            vad_pkg::TAG_LY_LX:      form = vad_pkg::FORM_LY_LX;
            vad_pkg::TAG_LY_HX_LX:   form = vad_pkg::FORM_LY_HX_LX;
            vad_pkg::TAG_LX:         form = vad_pkg::FORM_LX;
            vad_pkg::TAG_E_LY_LX:    form = vad_pkg::FORM_E_LY_LX;
            vad_pkg::TAG_HY_LY_LX:   form = vad_pkg::FORM_HY_LY_LX;
            vad_pkg::TAG_E_LY_HX_LX: form = vad_pkg::FORM_E_LY_HX_LX;
            vad_pkg::TAG_HY_E_LY_LX: form = vad_pkg::FORM_HY_E_LY_LX;
            vad_pkg::TAG_HY_HX_LX:   form = vad_pkg::FORM_HY_HX_LX;
            default:                 form_ok = 1'b0;
        endcase
    end

    // Address items with a bad count or unknown tag are consumed without a record.
    assign push = in_valid && in_ready && (operation || (count_ok && form_ok));

    always_comb begin
        cmd.form = operation ? vad_pkg::FORM_STEP : form;
        cmd.d0   = addr_byte0[4:0];
        cmd.d1   = addr_byte1[4:0];
        cmd.d2   = addr_byte2[4:0];
        cmd.d3   = addr_byte3[4:0];
        cmd.d4   = addr_byte4[4:0];
        cmd.dirs = step_dirs;
    end

endmodule

@@ rtl/core/vad_queue.sv @@
`timescale 1ns / 1ps

module vad_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  vad_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          not_empty,
    output logic          not_full,
    output vad_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    vad_pkg::cmd_t    store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != FULL_CNT);
    assign head_cmd  = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/vad_back.sv @@
`timescale 1ns / 1ps

module vad_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  vad_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  vad_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    record_kind,
    output logic [11:0]   pos_y,
    output logic [11:0]   pos_x,
    output logic [7:0]    glow,
    output logic          defocus_out,
    output logic          through_out,
    output logic [2:0]    style_out,
    output logic [6:0]    intensity_out
);

    localparam int CW = vad_pkg::COORD_W;

    logic [CW-1:0] beam_y_reg, beam_y_next;
    logic [CW-1:0] beam_x_reg, beam_x_next;
    logic          out_valid_reg;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    glow_reg;
    logic          defocus_reg;
    logic          through_reg;
    logic [2:0]    style_reg, style_next;
    logic [6:0]    inten_reg, inten_next;
    logic [CW-1:0] pos_y_reg;
    logic [CW-1:0] pos_x_reg;

    // Coordinate pieces: high bits 11:7, low bits 6:2, extra bits from an extra byte.
    function automatic logic [CW-1:0] hi_bits(input logic [4:0] d);
        hi_bits = {d, 7'b0};
    endfunction

    function automatic logic [CW-1:0] lo_bits(input logic [4:0] d);
        lo_bits = {5'b0, d, 2'b0};
    endfunction

    function automatic logic [CW-1:0] extra_y(input logic [4:0] d);
        extra_y = {9'b0, d[4:2]};
    endfunction

    function automatic logic [CW-1:0] extra_x(input logic [4:0] d);
        extra_x = {10'b0, d[1:0]};
    endfunction

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    always_comb begin
        beam_y_next = beam_y_reg;
        beam_x_next = beam_x_reg;
        unique case (cmd.form)
            vad_pkg::FORM_STEP: begin
                beam_y_next = beam_y_reg - {11'b0, cmd.dirs[3]} + {11'b0, cmd.dirs[2]};
                beam_x_next = beam_x_reg - {11'b0, cmd.dirs[1]} + {11'b0, cmd.dirs[0]};
            end
            vad_pkg::FORM_FULL12: begin
                beam_y_next = hi_bits(cmd.d0) | lo_bits(cmd.d2) | extra_y(cmd.d1);
                beam_x_next = hi_bits(cmd.d3) | lo_bits(cmd.d4) | extra_x(cmd.d1);
            end
            vad_pkg::FORM_FULL10: begin
                beam_y_next = hi_bits(cmd.d0) | lo_bits(cmd.d1);
                beam_x_next = hi_bits(cmd.d2) | lo_bits(cmd.d3);
            end
            vad_pkg::FORM_HY_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_LOW_EXTRA) | hi_bits(cmd.d0);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_HIGH_EXTRA) | lo_bits(cmd.d1);
            end
            vad_pkg::FORM_LY_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_HIGH_EXTRA) | lo_bits(cmd.d0);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_HIGH_EXTRA) | lo_bits(cmd.d1);
            end
            vad_pkg::FORM_LY_HX_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_HIGH_EXTRA) | lo_bits(cmd.d0);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_EXTRA) | hi_bits(cmd.d1)
                              | lo_bits(cmd.d2);
            end
            vad_pkg::FORM_LX: begin
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_HIGH_EXTRA) | lo_bits(cmd.d0);
            end
            vad_pkg::FORM_E_LY_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_HIGH) | lo_bits(cmd.d1)
                              | extra_y(cmd.d0);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_HIGH) | lo_bits(cmd.d2)
                              | extra_x(cmd.d0);
            end
            vad_pkg::FORM_HY_LY_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_EXTRA) | hi_bits(cmd.d0)
                              | lo_bits(cmd.d1);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_HIGH_EXTRA) | lo_bits(cmd.d2);
            end
            vad_pkg::FORM_E_LY_HX_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_HIGH) | lo_bits(cmd.d1)
                              | extra_y(cmd.d0);
                beam_x_next = hi_bits(cmd.d2) | lo_bits(cmd.d3) | extra_x(cmd.d0);
            end
            vad_pkg::FORM_HY_E_LY_LX: begin
                beam_y_next = hi_bits(cmd.d0) | lo_bits(cmd.d2) | extra_y(cmd.d1);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_HIGH) | lo_bits(cmd.d3)
                              | extra_x(cmd.d1);
            end
            vad_pkg::FORM_HY_HX_LX: begin
                beam_y_next = (beam_y_reg & vad_pkg::KEEP_LOW_EXTRA) | hi_bits(cmd.d0);
                beam_x_next = (beam_x_reg & vad_pkg::KEEP_EXTRA) | hi_bits(cmd.d1)
                              | lo_bits(cmd.d2);
            end
            default: begin
                beam_y_next = beam_y_reg;
                beam_x_next = beam_x_reg;
            end
        endcase
    end

    always_comb begin
        if (cmd.form == vad_pkg::FORM_STEP) begin
            kind_next  = cfg.pen_down ? vad_pkg::KIND_POINT : vad_pkg::KIND_MOVE;
            style_next = '0;
            inten_next = cfg.pen_down ? cfg.point_intensity : '0;
        end else begin
            kind_next  = cfg.draw_mode;
            style_next = (cfg.line_style > vad_pkg::STYLE_MAX) ? '0 : cfg.line_style;
            inten_next = cfg.point_intensity;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_y_reg    <= vad_pkg::BEAM_Y_HOME;
            beam_x_reg    <= vad_pkg::BEAM_X_HOME;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd_pop) begin
                beam_y_reg    <= beam_y_next;
                beam_x_reg    <= beam_x_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            kind_reg    <= kind_next;
            pos_y_reg   <= beam_y_next;
            pos_x_reg   <= beam_x_next;
            glow_reg    <= cfg.beam_write_through ? cfg.glow_through : cfg.glow_normal;
            defocus_reg <= cfg.beam_defocus;
            through_reg <= cfg.beam_write_through;
            style_reg   <= style_next;
            inten_reg   <= inten_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = kind_reg;
    assign pos_y         = pos_y_reg;
    assign pos_x         = pos_x_reg;
    assign glow          = glow_reg;
    assign defocus_out   = defocus_reg;
    assign through_out   = through_reg;
    assign style_out     = style_reg;
    assign intensity_out = inten_reg;

endmodule
